[hw/rtl/irctok_pkg.sv]
// ----------------------------------------------------------------------------
// irctok_pkg: shared types and constants of the line tokenizer
// Request payloads, controller states, datapath operations and status.
// ----------------------------------------------------------------------------
`default_nettype none

package irctok_pkg;

    // default sizes
    localparam int HOLD_DEPTH_DEF       = 32;
    localparam int MAX_TOKEN_NUMBER_DEF = 15;

    // characters of interest
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;

    // result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_END_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END_LINE  = 2'd2;

    // input request
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_last;
    } t_in;

    // output request
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic [3:0] token_number;
        logic       overflow_flag;
        logic       run_last;
    } t_out;

    // scanner mode
    typedef enum logic [2:0] {
        MODE_SKIP_VERB  = 3'd0,
        MODE_SKIP_PARAM = 3'd1,
        MODE_TOKEN      = 3'd2,
        MODE_COLON      = 3'd3,
        MODE_TRAIL      = 3'd4
    } t_mode;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPLAY,
        ST_COLON_CHAR,
        ST_COLON_END,
        ST_TAKE,
        ST_LAST,
        ST_EOL,
        ST_FLUSH
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_WS,
        OP_REPLAY,
        OP_COLON_CHAR,
        OP_COLON_END,
        OP_TAKE,
        OP_END_TOKEN,
        OP_END_LINE,
        OP_FLUSH
    } t_op;

    // datapath status toward the controller
    typedef struct packed {
        logic is_ws;
        logic last;
        logic held_any;
        logic replay_last;
        logic colon_pending;
        logic token_open;
        logic emit_ok;
    } t_status;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_space_class(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/irc_line_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// irc_line_tokenizer_core: text line tokenizer, top level
// Splits a byte stream of lines into verb and parameter tokens.
// ----------------------------------------------------------------------------
// One byte is taken per input request; the block then works on it alone and
// takes the next byte once every result of this one is staged. A byte is
// loaded and scanned, taken unless it is whitespace, then flushed. Held
// whitespace is replayed out of the hold memory first, one read per cycle
// while results can be staged, and the byte is rescanned; a held colon and
// space are then closed before the take; a line's last byte ends the line.
// Results leave through an output register, so a stalled consumer holds the
// controller only once a second result is waiting behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_line_tokenizer_core #(
    parameter int HOLD_DEPTH       = irctok_pkg::HOLD_DEPTH_DEF,
    parameter int MAX_TOKEN_NUMBER = irctok_pkg::MAX_TOKEN_NUMBER_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire irctok_pkg::t_in i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output irctok_pkg::t_out     o_out_data
);

    irctok_pkg::t_status status;
    irctok_pkg::t_op     op;

    // sequencing
    irctok_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_op       (op)
    );

    // line state, hold memory and result path
    irctok_dp #(
        .HOLD_DEPTH       (HOLD_DEPTH),
        .MAX_TOKEN_NUMBER (MAX_TOKEN_NUMBER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_op        (op),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[hw/rtl/irctok_dp.sv]
// ----------------------------------------------------------------------------
// irctok_dp: tokenizer datapath
// Line state, whitespace hold memory, result staging and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module irctok_dp #(
    parameter int HOLD_DEPTH       = irctok_pkg::HOLD_DEPTH_DEF,
    parameter int MAX_TOKEN_NUMBER = irctok_pkg::MAX_TOKEN_NUMBER_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire irctok_pkg::t_in    i_in_data,
    input  wire irctok_pkg::t_op    i_op,
    output irctok_pkg::t_status     o_status,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output irctok_pkg::t_out        o_out_data
);

    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int TOK_W = $clog2(MAX_TOKEN_NUMBER + 1);
    localparam logic [CNT_W-1:0] HOLD_FULL = CNT_W'(HOLD_DEPTH);
    localparam logic [TOK_W-1:0] TOK_MAX   = TOK_W'(MAX_TOKEN_NUMBER);

    logic [7:0]              r_char, n_char;
    logic                    r_last, n_last;
    irctok_pkg::t_mode       r_mode, n_mode;
    logic                    r_cts, n_cts;
    logic [TOK_W-1:0]        r_tok, n_tok;
    logic                    r_has_tok, n_has_tok;
    logic                    r_ovf, n_ovf;
    logic [CNT_W-1:0]        r_held_cnt, n_held_cnt;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [7:0]              r_rd;
    logic [7:0]              r_held [HOLD_DEPTH];
    logic                    r_pend_valid, n_pend_valid;
    irctok_pkg::t_out        r_pend, n_pend;
    logic                    r_out_valid, n_out_valid;
    irctok_pkg::t_out        r_out, n_out;

    logic                    hold_we;
    logic                    emit;
    irctok_pkg::t_out        res;
    logic [7:0]              tb;
    logic                    tb_ws;
    logic                    replay_last;
    logic                    emit_ok;

    // replay pointer reaches the last held byte
    assign replay_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_held_cnt);
    assign emit_ok     = !r_pend_valid || !r_out_valid || i_out_ready;

    // byte under scan: held whitespace during replay, else the latched byte
    assign tb    = (i_op == irctok_pkg::OP_REPLAY) ? r_rd : r_char;
    assign tb_ws = irctok_pkg::is_space_class(tb);

    // line state and result generation
    always_comb begin
        n_char     = r_char;
        n_last     = r_last;
        n_mode     = r_mode;
        n_cts      = r_cts;
        n_tok      = r_tok;
        n_has_tok  = r_has_tok;
        n_ovf      = r_ovf;
        n_held_cnt = r_held_cnt;
        n_idx      = r_idx;
        hold_we    = 1'b0;
        emit       = 1'b0;
        res        = '0;

        case (i_op)
            irctok_pkg::OP_LOAD: begin
                n_char = i_in_data.char_in;
                n_last = i_in_data.line_last;
                n_idx  = '0;
            end
            irctok_pkg::OP_SCAN_WS: begin
                if ((r_mode == irctok_pkg::MODE_TOKEN) ||
                    (r_mode == irctok_pkg::MODE_TRAIL)) begin
                    hold_we = 1'b1;
                end else if (r_mode == irctok_pkg::MODE_COLON) begin
                    if (!r_cts) begin
                        if (r_char == irctok_pkg::CHAR_SPACE) begin
                            n_cts = 1'b1;
                        end else begin
                            n_mode  = irctok_pkg::MODE_TRAIL;
                            hold_we = 1'b1;
                        end
                    end
                end
                // hold buffer full: drop the byte, flag it
                if (hold_we) begin
                    if (r_held_cnt < HOLD_FULL) begin
                        n_held_cnt = r_held_cnt + CNT_W'(1);
                    end else begin
                        hold_we = 1'b0;
                        n_ovf   = 1'b1;
                    end
                end
            end
            irctok_pkg::OP_REPLAY, irctok_pkg::OP_TAKE: begin
                if (i_op == irctok_pkg::OP_REPLAY) begin
                    if (replay_last) begin
                        n_idx      = '0;
                        n_held_cnt = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                case (r_mode)
                    irctok_pkg::MODE_TOKEN: begin
                        emit = 1'b1;
                        if (tb == irctok_pkg::CHAR_SPACE) begin
                            res.kind = irctok_pkg::KIND_END_TOKEN;
                            n_mode   = irctok_pkg::MODE_SKIP_PARAM;
                        end else begin
                            res.kind     = irctok_pkg::KIND_BYTE;
                            res.char_out = tb;
                        end
                    end
                    irctok_pkg::MODE_COLON, irctok_pkg::MODE_TRAIL: begin
                        emit         = 1'b1;
                        res.kind     = irctok_pkg::KIND_BYTE;
                        res.char_out = tb;
                        n_mode       = irctok_pkg::MODE_TRAIL;
                    end
                    default: begin
                        // skipping whitespace before verb or parameter
                        if (!tb_ws) begin
                            if (r_has_tok) begin
                                if (r_tok >= TOK_MAX) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_tok = r_tok + TOK_W'(1);
                                end
                            end else begin
                                n_has_tok = 1'b1;
                                n_tok     = '0;
                            end
                            if ((r_mode == irctok_pkg::MODE_SKIP_PARAM) &&
                                (tb == irctok_pkg::CHAR_COLON)) begin
                                n_mode = irctok_pkg::MODE_COLON;
                                n_cts  = 1'b0;
                            end else begin
                                emit         = 1'b1;
                                res.kind     = irctok_pkg::KIND_BYTE;
                                res.char_out = tb;
                                n_mode       = irctok_pkg::MODE_TOKEN;
                            end
                        end
                    end
                endcase
            end
            irctok_pkg::OP_COLON_CHAR: begin
                emit         = 1'b1;
                res.kind     = irctok_pkg::KIND_BYTE;
                res.char_out = irctok_pkg::CHAR_COLON;
            end
            irctok_pkg::OP_COLON_END: begin
                emit     = 1'b1;
                res.kind = irctok_pkg::KIND_END_TOKEN;
                n_mode   = irctok_pkg::MODE_SKIP_PARAM;
                n_cts    = 1'b0;
            end
            irctok_pkg::OP_END_TOKEN: begin
                emit     = 1'b1;
                res.kind = irctok_pkg::KIND_END_TOKEN;
            end
            irctok_pkg::OP_END_LINE: begin
                emit       = 1'b1;
                res.kind   = irctok_pkg::KIND_END_LINE;
                n_held_cnt = '0;
                n_mode     = irctok_pkg::MODE_SKIP_VERB;
                n_cts      = 1'b0;
                n_tok      = '0;
                n_has_tok  = 1'b0;
                n_ovf      = 1'b0;
            end
            default: begin
            end
        endcase

        // end of line reports the values before the line state clears
        if (i_op == irctok_pkg::OP_END_LINE) begin
            res.token_number  = 4'(r_tok);
            res.overflow_flag = r_ovf;
        end else begin
            res.token_number  = 4'(n_tok);
            res.overflow_flag = n_ovf;
        end
        res.run_last = 1'b0;
    end

    // staging: a result waits in a pending register so the last of a byte can be marked
    always_comb begin
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        if (emit) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out_valid = 1'b1;
            end
            n_pend       = res;
            n_pend_valid = 1'b1;
        end else if ((i_op == irctok_pkg::OP_FLUSH) && r_pend_valid) begin
            n_out          = r_pend;
            n_out.run_last = 1'b1;
            n_out_valid    = 1'b1;
            n_pend_valid   = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= irctok_pkg::MODE_SKIP_VERB;
            r_cts        <= 1'b0;
            r_tok        <= '0;
            r_has_tok    <= 1'b0;
            r_ovf        <= 1'b0;
            r_held_cnt   <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_cts        <= n_cts;
            r_tok        <= n_tok;
            r_has_tok    <= n_has_tok;
            r_ovf        <= n_ovf;
            r_held_cnt   <= n_held_cnt;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // whitespace hold memory, read one entry ahead of the replay pointer
    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            r_held[r_held_cnt[IDX_W-1:0]] <= r_char;
        end
        r_rd <= r_held[n_idx];
    end

    // status toward the controller
    always_comb begin
        o_status.is_ws         = irctok_pkg::is_space_class(r_char);
        o_status.last          = r_last;
        o_status.held_any      = (r_held_cnt != '0);
        o_status.replay_last   = replay_last;
        o_status.colon_pending = (r_mode == irctok_pkg::MODE_COLON) && r_cts;
        o_status.token_open    = r_mode inside {irctok_pkg::MODE_TOKEN,
                                                irctok_pkg::MODE_TRAIL,
                                                irctok_pkg::MODE_COLON};
        o_status.emit_ok       = emit_ok;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[hw/rtl/irctok_ctrl.sv]
// ----------------------------------------------------------------------------
// irctok_ctrl: tokenizer controller
// Steps the datapath through one input byte: scan, replay, emit, flush.
// ----------------------------------------------------------------------------
`default_nettype none

module irctok_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire irctok_pkg::t_status i_status,
    output irctok_pkg::t_op          o_op
);

    irctok_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irctok_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath operation
    always_comb begin
        n_state    = r_state;
        o_op       = irctok_pkg::OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            irctok_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = irctok_pkg::OP_LOAD;
                    n_state = irctok_pkg::ST_SCAN;
                end
            end
            irctok_pkg::ST_SCAN: begin
                if (i_status.is_ws) begin
                    o_op    = irctok_pkg::OP_SCAN_WS;
                    n_state = i_status.last ? irctok_pkg::ST_LAST : irctok_pkg::ST_FLUSH;
                end else if (i_status.held_any) begin
                    n_state = irctok_pkg::ST_REPLAY;
                end else if (i_status.colon_pending) begin
                    n_state = irctok_pkg::ST_COLON_CHAR;
                end else begin
                    n_state = irctok_pkg::ST_TAKE;
                end
            end
            irctok_pkg::ST_REPLAY: begin
                if (i_status.emit_ok) begin
                    o_op = irctok_pkg::OP_REPLAY;
                    if (i_status.replay_last) begin
                        n_state = irctok_pkg::ST_SCAN;
                    end
                end
            end
            irctok_pkg::ST_COLON_CHAR: begin
                if (i_status.emit_ok) begin
                    o_op    = irctok_pkg::OP_COLON_CHAR;
                    n_state = irctok_pkg::ST_COLON_END;
                end
            end
            irctok_pkg::ST_COLON_END: begin
                if (i_status.emit_ok) begin
                    o_op    = irctok_pkg::OP_COLON_END;
                    n_state = irctok_pkg::ST_TAKE;
                end
            end
            irctok_pkg::ST_TAKE: begin
                if (i_status.emit_ok) begin
                    o_op    = irctok_pkg::OP_TAKE;
                    n_state = i_status.last ? irctok_pkg::ST_LAST : irctok_pkg::ST_FLUSH;
                end
            end
            irctok_pkg::ST_LAST: begin
                if (i_status.emit_ok) begin
                    if (i_status.token_open) begin
                        o_op    = irctok_pkg::OP_END_TOKEN;
                        n_state = irctok_pkg::ST_EOL;
                    end else begin
                        o_op    = irctok_pkg::OP_END_LINE;
                        n_state = irctok_pkg::ST_FLUSH;
                    end
                end
            end
            irctok_pkg::ST_EOL: begin
                if (i_status.emit_ok) begin
                    o_op    = irctok_pkg::OP_END_LINE;
                    n_state = irctok_pkg::ST_FLUSH;
                end
            end
            irctok_pkg::ST_FLUSH: begin
                if (i_status.emit_ok) begin
                    o_op    = irctok_pkg::OP_FLUSH;
                    n_state = irctok_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = irctok_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/irc_line_tokenizer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irc_line_tokenizer_core_tb: self-checking bench for the line tokenizer
// Feeds text lines one byte per request with random gaps and output stalls,
// runs a behavioral scanner next to the block and compares every token event
// in order. A short scripted part covers the corner cases, then random lines.
// ----------------------------------------------------------------------------

module irc_line_tokenizer_core_tb;
    import irctok_pkg::*;

    localparam int HOLD_N       = HOLD_DEPTH_DEF;
    localparam int TOK_MAX      = MAX_TOKEN_NUMBER_DEF;
    localparam int EVENT_CAP    = 36;
    localparam int RAND_BYTES   = 200;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_LIMIT   = 200000;

    localparam t_out EOL_BLANK = '{kind: KIND_END_LINE, char_out: 8'h00,
                                   token_number: 4'd0, overflow_flag: 1'b0,
                                   run_last: 1'b1};

    // random line shapes
    typedef enum int {
        LN_PLAIN,
        LN_MANY,
        LN_LONG_WS,
        LN_COLON,
        LN_NOISE,
        LN_BLANK
    } t_shape;

    // scripted request: byte, repeat count and an optional typed result
    typedef struct {
        logic [7:0] ch;
        bit         last;
        int         rep;
        bit         typed;
        t_out       want;
    } t_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // scanner state of the prediction
    t_mode      scan_md     = MODE_SKIP_VERB;
    logic [7:0] ws_hold [HOLD_N];
    int         ws_cnt      = 0;
    bit         colon_sp    = 1'b0;
    int         tok_num     = 0;
    bit         tok_open_ln = 1'b0;
    bit         ovf_ln      = 1'b0;

    t_out       step_q[$];
    t_out       token_events_q[$];
    t_row       script_q[$];
    logic [7:0] line_q[$];

    int err_cnt   = 0;
    int res_cnt   = 0;
    int ovf_res   = 0;
    int lines_cnt = 0;
    int bytes_cnt = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;
    int out_run   = 0;
    int out_stall = 0;

    irc_line_tokenizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // six whitespace bytes
    function automatic bit ws_byte(input logic [7:0] c);
        case (c)
            CHAR_SPACE, CHAR_TAB, 8'h0a, 8'h0b, 8'h0c, CHAR_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // append one byte to the line under construction
    function automatic void line_add(input logic [7:0] c);
        line_q = {line_q, c};
    endfunction

    function automatic void emit(input logic [1:0] k, input logic [7:0] c);
        t_out r;
        if (step_q.size() >= EVENT_CAP)
            return;
        r.kind          = k;
        r.char_out      = c;
        r.token_number  = 4'(tok_num);
        r.overflow_flag = ovf_ln;
        r.run_last      = 1'b0;
        step_q = {step_q, r};
    endfunction

    // number a new token, saturating
    function automatic void open_token();
        if (tok_open_ln) begin
            if (tok_num >= TOK_MAX)
                ovf_ln = 1'b1;
            else
                tok_num++;
        end else begin
            tok_open_ln = 1'b1;
            tok_num     = 0;
        end
    endfunction

    function automatic void hold_ws(input logic [7:0] c);
        if (ws_cnt < HOLD_N) begin
            ws_hold[ws_cnt] = c;
            ws_cnt++;
        end else begin
            ovf_ln = 1'b1;
        end
    endfunction

    // one byte known to lie inside the trimmed line
    function automatic void feed_trimmed(input logic [7:0] c);
        case (scan_md)
            MODE_SKIP_PARAM: begin
                if (!ws_byte(c)) begin
                    open_token();
                    if (c == CHAR_COLON) begin
                        scan_md  = MODE_COLON;
                        colon_sp = 1'b0;
                    end else begin
                        emit(KIND_BYTE, c);
                        scan_md = MODE_TOKEN;
                    end
                end
            end
            MODE_TOKEN: begin
                if (c == CHAR_SPACE) begin
                    emit(KIND_END_TOKEN, 8'h00);
                    scan_md = MODE_SKIP_PARAM;
                end else begin
                    emit(KIND_BYTE, c);
                end
            end
            MODE_COLON: begin
                scan_md = MODE_TRAIL;
                emit(KIND_BYTE, c);
            end
            MODE_TRAIL: emit(KIND_BYTE, c);
            default: begin
                if (!ws_byte(c)) begin
                    open_token();
                    emit(KIND_BYTE, c);
                    scan_md = MODE_TOKEN;
                end
            end
        endcase
    endfunction

    // token events caused by one byte request, left in step_q
    function automatic void tokenize_byte(input t_in req);
        logic [7:0] c;
        int         i;
        c = req.char_in;
        step_q.delete();
        if (ws_byte(c)) begin
            if (scan_md == MODE_TOKEN || scan_md == MODE_TRAIL) begin
                hold_ws(c);
            end else if (scan_md == MODE_COLON && !colon_sp) begin
                if (c == CHAR_SPACE) begin
                    colon_sp = 1'b1;
                end else begin
                    scan_md = MODE_TRAIL;
                    hold_ws(c);
                end
            end
        end else begin
            // a visible byte releases the held whitespace run
            for (i = 0; i < ws_cnt; i++)
                feed_trimmed(ws_hold[i]);
            ws_cnt = 0;
            if (scan_md == MODE_COLON && colon_sp) begin
                emit(KIND_BYTE, CHAR_COLON);
                emit(KIND_END_TOKEN, 8'h00);
                scan_md  = MODE_SKIP_PARAM;
                colon_sp = 1'b0;
            end
            feed_trimmed(c);
        end
        // end of line drops held whitespace and clears line state
        if (req.line_last) begin
            ws_cnt = 0;
            if (scan_md == MODE_TOKEN || scan_md == MODE_TRAIL || scan_md == MODE_COLON)
                emit(KIND_END_TOKEN, 8'h00);
            emit(KIND_END_LINE, 8'h00);
            scan_md     = MODE_SKIP_VERB;
            colon_sp    = 1'b0;
            tok_num     = 0;
            tok_open_ln = 1'b0;
            ovf_ln      = 1'b0;
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].run_last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // compare one accepted result with the oldest pending event
    task automatic check_event(input t_out got);
        t_out want;
        res_cnt++;
        if (got.overflow_flag === 1'b1)
            ovf_res++;
        if (token_events_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing pending", got));
        end else begin
            want = token_events_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.char_out !== want.char_out)
                report_mismatch($sformatf("char_out %h, want %h",
                                          got.char_out, want.char_out));
            if (got.token_number !== want.token_number)
                report_mismatch($sformatf("token_number %0d, want %0d",
                                          got.token_number, want.token_number));
            if (got.overflow_flag !== want.overflow_flag)
                report_mismatch($sformatf("overflow_flag %b, want %b",
                                          got.overflow_flag, want.overflow_flag));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, want %b",
                                          got.run_last, want.run_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_event(o_out_data);
    end

    // result side: random stalls with steady stretches
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (out_run == 0) begin
                out_steady = ($urandom_range(0, 3) == 0);
                out_run    = $urandom_range(8, 40);
            end
            out_run--;
            out_stall = out_steady ? 0 : $urandom_range(0, 14);
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (out_stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // one byte request, valid held until accepted
    task automatic send_req(input t_in req, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_cnt++;
    endtask

    task automatic push_byte(input logic [7:0] ch, input bit last, input bit typed,
                             input t_out want);
        t_in req;
        req.char_in   = ch;
        req.line_last = last;
        send_req(req, in_steady ? 0 : $urandom_range(0, 14));
        tokenize_byte(req);
        if (typed)
            token_events_q = {token_events_q, want};
        else
            token_events_q = {token_events_q, step_q};
        if (last)
            lines_cnt++;
    endtask

    // hold off the sender until every pending event has come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (token_events_q.size() != 0);
    endtask

    function automatic void add_row(input logic [7:0] ch, input bit last, input int rep,
                                    input bit typed, input t_out want);
        t_row r;
        r.ch    = ch;
        r.last  = last;
        r.rep   = rep;
        r.typed = typed;
        r.want  = want;
        script_q = {script_q, r};
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 9))
            0: return CHAR_TAB;
            1: return 8'h0a;
            2: return 8'h0b;
            3: return 8'h0c;
            4: return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    function automatic void add_token(input int n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(0, 255)); while (ws_byte(c));
            line_add(c);
        end
    endfunction

    function automatic void add_ws(input int n);
        repeat (n) line_add(pick_ws());
    endfunction

    // trailing text mixes visible bytes and whitespace
    function automatic void add_text(input int n);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                add_ws(1);
            else
                add_token(1);
        end
    endfunction

    function automatic t_shape pick_shape();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return LN_PLAIN;
            4:          return LN_MANY;
            5:          return LN_LONG_WS;
            6, 7:       return LN_COLON;
            8:          return LN_NOISE;
            default:    return LN_BLANK;
        endcase
    endfunction

    function automatic void build_line(input t_shape sh);
        int  n;
        int  k;
        bit  trailing;
        line_q.delete();
        case (sh)
            LN_MANY: begin
                n = $urandom_range(17, 20);
                for (k = 0; k < n; k++) begin
                    if (k > 0)
                        line_add(CHAR_SPACE);
                    add_token($urandom_range(1, 2));
                end
            end
            LN_LONG_WS: begin
                add_token(2);
                add_ws($urandom_range(28, 40));
                add_token(1);
                if ($urandom_range(0, 1) == 1)
                    add_ws($urandom_range(1, 40));
            end
            LN_COLON: begin
                add_token(3);
                line_add(CHAR_SPACE);
                line_add(CHAR_COLON);
                case ($urandom_range(0, 4))
                    0: add_ws(0);
                    1: line_add(CHAR_SPACE);
                    2: begin
                        line_add(CHAR_SPACE);
                        add_token(2);
                    end
                    3: begin
                        line_add(CHAR_TAB);
                        add_ws($urandom_range(0, 3));
                    end
                    default: begin
                        line_add(pick_ws());
                        add_text(3);
                    end
                endcase
            end
            LN_NOISE: begin
                repeat ($urandom_range(1, 10)) line_add(8'($urandom_range(0, 255)));
            end
            LN_BLANK: add_ws($urandom_range(0, 3));
            default: begin
                add_ws($urandom_range(0, 2));
                add_token($urandom_range(1, 6));
                n        = $urandom_range(0, 4);
                trailing = 1'b0;
                for (k = 0; k < n && !trailing; k++) begin
                    line_add(CHAR_SPACE);
                    add_ws($urandom_range(0, 2));
                    if ($urandom_range(0, 3) == 0) begin
                        line_add(CHAR_COLON);
                        add_text($urandom_range(0, 8));
                        trailing = 1'b1;
                    end else begin
                        add_token($urandom_range(1, 5));
                    end
                end
                add_ws($urandom_range(0, 2));
            end
        endcase
        if (line_q.size() == 0)
            line_add(pick_ws());
    endfunction

    // stimulus
    initial begin
        t_row row;
        int   k;
        int   rnd_items;
        int   line_no;
        int   idle_wait;
        bit   last;

        // empty line straight after reset
        add_row(8'h0a, 1'b1, 1, 1'b1, EOL_BLANK);
        // verb with extreme byte, colon-space token, zero byte, colon-tab tail
        add_row(CHAR_SPACE, 1'b0, 1, 1'b0, '0);
        add_row(8'h50, 1'b0, 1, 1'b0, '0);
        add_row(8'hff, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_SPACE, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_COLON, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_SPACE, 1'b0, 1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_COLON, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_SPACE, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_COLON, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_TAB, 1'b0, 1, 1'b0, '0);
        add_row(8'h0b, 1'b1, 1, 1'b0, '0);
        // lone colon closing the line
        add_row(8'h41, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_SPACE, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_COLON, 1'b1, 1, 1'b0, '0);
        // whitespace-only line
        add_row(CHAR_CR, 1'b0, 1, 1'b0, '0);
        add_row(8'h0c, 1'b1, 1, 1'b1, EOL_BLANK);
        // hold memory overrun inside a token
        add_row(8'h76, 1'b0, 1, 1'b0, '0);
        add_row(CHAR_SPACE, 1'b0, HOLD_N + 2, 1'b0, '0);
        add_row(8'h77, 1'b0, 1, 1'b0, '0);
        add_row(8'h0a, 1'b1, 1, 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_q[i]) begin
            row       = script_q[i];
            in_steady = ($urandom_range(0, 2) == 0);
            for (k = 0; k < row.rep; k++)
                push_byte(row.ch, row.last, row.typed, row.want);
        end
        wait_idle();

        // random lines, first one saturates the token count
        rnd_items = 0;
        line_no   = 0;
        while (rnd_items < RAND_BYTES) begin
            if (line_no > 0 && line_no % 12 == 0)
                wait_idle();
            in_steady = ($urandom_range(0, 3) == 0);
            build_line(line_no == 0 ? LN_MANY : pick_shape());
            for (k = 0; k < line_q.size(); k++) begin
                last = (k == line_q.size() - 1);
                push_byte(line_q[k], last, 1'b0, '0);
                rnd_items++;
            end
            line_no++;
        end

        // drain
        i_in_valid <= 1'b0;
        idle_wait = 0;
        while (token_events_q.size() != 0 && idle_wait < IDLE_LIMIT) begin
            @(posedge i_clk);
            idle_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (token_events_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", token_events_q.size()));

        $display("covered %0d lines in %0d byte requests, %0d results checked",
                 lines_cnt, bytes_cnt, res_cnt);
        $display("%0d results flagged overflow, %0d mismatches", ovf_res, err_cnt);
        if (err_cnt == 0)
            $display("irc_line_tokenizer_core_tb: done, clean");
        else
            $display("irc_line_tokenizer_core_tb: done, errors");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("irc_line_tokenizer_core_tb: done, errors");
        $finish;
    end

endmodule
